FILE: rtl/rgcd_pkg.sv
// ----------------------------------------------------------------------------
// rgcd_pkg
// Shared types and constants for the fraction arithmetic block with gcd
// reduction: operation and status codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rgcd_pkg;

    // Default operand width and fixed field widths.
    localparam int DEF_OPERAND_WIDTH = 16;
    localparam int KIND_W            = 3;
    localparam int RES_W             = 32;
    localparam int STATUS_W          = 2;
    localparam int OUT_FIELDS_W      = 2 * RES_W + STATUS_W + 2;
    localparam int OUT_TDATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Largest result magnitude; larger values saturate here.
    localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;

    // Operation codes carried with each input item.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_CMP = 3'd4
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_DIV_ZERO  = 2'd1,
        STAT_ZERO_DEN  = 2'd2
    } status_t;

    // Which of the three products the shared multiplier forms.
    typedef enum logic [1:0] {
        MSEL_P = 2'd0,
        MSEL_Q = 2'd1,
        MSEL_D = 2'd2
    } mul_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_Q,
        S_MUL_D,
        S_COMBINE,
        S_GCD,
        S_DIV_NUM,
        S_LOAD_DEN,
        S_DIV_DEN,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     combine;
        logic     gcd_step;
        logic     div_init_num;
        logic     div_init_den;
        logic     div_step;
        logic     out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic gcd_done;
    } dp_stat_t;

endpackage

FILE: rtl/rational_arithmetic_gcd_reduce.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_gcd_reduce
// Signed fraction add, subtract, multiply, divide and exact compare, with the
// arithmetic results reduced by the gcd of numerator and denominator.
// ----------------------------------------------------------------------------
// Sequence: compare, error and unused-code items go from the products straight
//   to the result; other items also run the binary gcd loop and the
//   one-bit-per-cycle divider for the numerator and then the denominator.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: aresetn (synchronous, active low) clears the controller and m_tvalid.
module rational_arithmetic_gcd_reduce
    import rgcd_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // s_tdata: a_num, a_den, b_num, b_den (OPERAND_WIDTH bits each), zero pad.
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]     s_tdata,
    // s_tuser: kind.
    input  logic [KIND_W-1:0]                        s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // m_tdata: res_num, res_den, status, is_less, is_greater, zero pad.
    output logic [OUT_TDATA_W-1:0]                   m_tdata
);

    localparam int W = OPERAND_WIDTH;

    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    logic signed [W-1:0]     a_num, a_den, b_num, b_den;
    logic signed [RES_W-1:0] res_num, res_den;
    logic [STATUS_W-1:0]     status;
    logic                    is_less, is_greater;

    // Unpack the input item.
    assign a_num = s_tdata[0*W +: W];
    assign a_den = s_tdata[1*W +: W];
    assign b_num = s_tdata[2*W +: W];
    assign b_den = s_tdata[3*W +: W];

    rgcd_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rgcd_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (s_tuser),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .res_num    (res_num),
        .res_den    (res_den),
        .status     (status),
        .is_less    (is_less),
        .is_greater (is_greater)
    );

    // Pack the result item.
    assign m_tdata = OUT_TDATA_W'({is_greater, is_less, status, res_den, res_num});

endmodule

FILE: rtl/rgcd_dp.sv
// ----------------------------------------------------------------------------
// rgcd_dp
// Datapath: operand magnitudes and signs, one shared multiplier, the signed
// cross-product sum, a binary gcd unit, a shared restoring divider and the
// result register.
// ----------------------------------------------------------------------------
module rgcd_dp
    import rgcd_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
    input  logic                            aclk,
    input  dp_cmd_t                         cmd,
    output dp_stat_t                        stat,
    input  logic [KIND_W-1:0]               kind,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic signed [RES_W-1:0]         res_num,
    output logic signed [RES_W-1:0]         res_den,
    output logic [STATUS_W-1:0]             status,
    output logic                            is_less,
    output logic                            is_greater
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int KW = $clog2(MW + 1);
    localparam int XW = (MW > RES_W) ? MW : RES_W;

    // Magnitude of a signed operand; the most negative code maps correctly.
    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        logic [W-1:0] ux;
        ux = x;
        return x[W-1] ? (W'(0) - ux) : ux;
    endfunction

    // Saturate a magnitude and apply its sign.
    function automatic logic [RES_W-1:0] enc(input logic neg, input logic [MW-1:0] m);
        logic [XW-1:0]    e;
        logic [RES_W-1:0] s;
        e = XW'(m);
        if (e > XW'(RES_MAX)) begin
            s = RES_MAX;
        end else begin
            s = e[RES_W-1:0];
        end
        return neg ? (RES_W'(0) - s) : s;
    endfunction

    // Operand registers.
    logic [KIND_W-1:0] kind_reg;
    logic [W-1:0]      an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic              an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic              zden_reg, bnz_reg;

    // Products, combined terms, gcd and divider registers.
    logic [MW-1:0] p_reg, q_reg, d_reg;
    logic [MW-1:0] nm_reg, dm_reg;
    logic          nneg_reg, dneg_reg, less_reg, greater_reg;
    logic [MW-1:0] u_reg, v_reg, g_reg;
    logic [KW-1:0] k_reg;
    logic [MW-1:0] rem_reg, quo_reg, nq_reg;

    // Result registers.
    logic signed [RES_W-1:0] res_num_reg, res_den_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic                    less_out_reg, greater_out_reg;

    // Decoded operation.
    logic is_mul, is_sub, is_addsub, is_cmp, is_div, bad_kind, div_zero;
    assign is_mul    = (kind_reg == KIND_MUL);
    assign is_sub    = (kind_reg == KIND_SUB);
    assign is_addsub = (kind_reg == KIND_ADD) || (kind_reg == KIND_SUB);
    assign is_cmp    = (kind_reg == KIND_CMP);
    assign is_div    = (kind_reg == KIND_DIV);
    assign bad_kind  = (kind_reg > KIND_CMP);
    assign div_zero  = is_div && bnz_reg;

    assign stat.skip     = bad_kind || zden_reg || div_zero || is_cmp;
    assign stat.gcd_done = (u_reg == '0) || (v_reg == '0);

    // Capture the operands of an accepted item.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= kind;
            an_m_reg <= mag(a_num);
            ad_m_reg <= mag(a_den);
            bn_m_reg <= mag(b_num);
            bd_m_reg <= mag(b_den);
            an_s_reg <= a_num[W-1];
            ad_s_reg <= a_den[W-1];
            bn_s_reg <= b_num[W-1];
            bd_s_reg <= b_den[W-1];
            zden_reg <= (a_den == '0) || (b_den == '0);
            bnz_reg  <= (b_num == '0);
        end
    end

    // Shared multiplier operand selection.
    logic [W-1:0]  mul_a, mul_b;
    logic [MW-1:0] prod;

    always_comb begin
        mul_a = ad_m_reg;
        mul_b = bd_m_reg;
        unique case (cmd.mul_sel)
            MSEL_P: begin
                mul_a = an_m_reg;
                mul_b = is_mul ? bn_m_reg : bd_m_reg;
            end
            MSEL_Q: begin
                mul_a = ad_m_reg;
                mul_b = is_mul ? bd_m_reg : bn_m_reg;
            end
            MSEL_D: begin
                mul_a = ad_m_reg;
                mul_b = bd_m_reg;
            end
            default: begin
                mul_a = ad_m_reg;
                mul_b = bd_m_reg;
            end
        endcase
    end

    assign prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                MSEL_P:  p_reg <= prod;
                MSEL_Q:  q_reg <= prod;
                default: d_reg <= prod;
            endcase
        end
    end

    // Sign-magnitude combination of the products, and the exact compare.
    logic          p_nz, q_nz, psign, qsign, pn, qn, p_ge_q, p_gt_q;
    logic [MW-1:0] sm;
    logic          sneg;
    logic [MW-1:0] nm_next, dm_next;
    logic          nneg_next, dneg_next, lneg, rneg, less_next, greater_next;

    always_comb begin
        p_nz   = (p_reg != '0);
        q_nz   = (q_reg != '0);
        psign  = an_s_reg ^ (is_mul ? bn_s_reg : bd_s_reg);
        qsign  = ad_s_reg ^ (is_mul ? bd_s_reg : bn_s_reg);
        pn     = psign & p_nz;
        qn     = (qsign ^ is_sub) & q_nz;
        p_ge_q = (p_reg >= q_reg);
        p_gt_q = (p_reg > q_reg);

        if (pn == qn) begin
            sm   = p_reg + q_reg;
            sneg = pn;
        end else if (p_ge_q) begin
            sm   = p_reg - q_reg;
            sneg = pn;
        end else begin
            sm   = q_reg - p_reg;
            sneg = qn;
        end
        sneg = sneg & (sm != '0);

        nm_next   = is_addsub ? sm : p_reg;
        nneg_next = is_addsub ? sneg : pn;
        dm_next   = is_addsub ? d_reg : q_reg;
        dneg_next = is_addsub ? (ad_s_reg ^ bd_s_reg) : qsign;

        // Both sides scaled by the positive denominators.
        lneg = (an_s_reg ^ ad_s_reg) & p_nz;
        rneg = (bn_s_reg ^ bd_s_reg) & q_nz;
        if (lneg != rneg) begin
            less_next    = lneg;
            greater_next = rneg;
        end else if (lneg) begin
            less_next    = p_gt_q;
            greater_next = !p_ge_q;
        end else begin
            less_next    = !p_ge_q;
            greater_next = p_gt_q;
        end
    end

    // Binary gcd: one shift or one subtract per cycle.
    logic [MW-1:0] g_val;
    assign g_val = (u_reg | v_reg) << k_reg;

    always_ff @(posedge aclk) begin
        if (cmd.combine) begin
            nm_reg      <= nm_next;
            dm_reg      <= dm_next;
            nneg_reg    <= nneg_next;
            dneg_reg    <= dneg_next;
            less_reg    <= less_next;
            greater_reg <= greater_next;
            u_reg       <= nm_next;
            v_reg       <= dm_next;
            k_reg       <= '0;
        end else if (cmd.gcd_step) begin
            if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_reg >= v_reg) begin
                u_reg <= u_reg - v_reg;
            end else begin
                v_reg <= v_reg - u_reg;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle, shared by both terms.
    logic [MW:0] trial;
    assign trial = {rem_reg, quo_reg[MW-1]} - {1'b0, g_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init_num) begin
            g_reg   <= g_val;
            rem_reg <= '0;
            quo_reg <= nm_reg;
        end else if (cmd.div_init_den) begin
            nq_reg  <= quo_reg;
            rem_reg <= '0;
            quo_reg <= dm_reg;
        end else if (cmd.div_step) begin
            if (!trial[MW]) begin
                rem_reg <= trial[MW-1:0];
                quo_reg <= {quo_reg[MW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[MW-2:0], quo_reg[MW-1]};
                quo_reg <= {quo_reg[MW-2:0], 1'b0};
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_num_reg     <= '0;
            res_den_reg     <= '0;
            status_reg      <= STAT_OK;
            less_out_reg    <= 1'b0;
            greater_out_reg <= 1'b0;
            if (bad_kind) begin
                status_reg <= STAT_OK;
            end else if (zden_reg) begin
                status_reg <= STAT_ZERO_DEN;
            end else if (div_zero) begin
                status_reg <= STAT_DIV_ZERO;
            end else if (is_cmp) begin
                less_out_reg    <= less_reg;
                greater_out_reg <= greater_reg;
            end else begin
                res_num_reg <= enc(nneg_reg, nq_reg);
                res_den_reg <= enc(dneg_reg, quo_reg);
            end
        end
    end

    assign res_num    = res_num_reg;
    assign res_den    = res_den_reg;
    assign status     = status_reg;
    assign is_less    = less_out_reg;
    assign is_greater = greater_out_reg;

endmodule

FILE: rtl/rgcd_ctrl.sv
// ----------------------------------------------------------------------------
// rgcd_ctrl
// Controller: sequences the products, the gcd loop and the two divisions,
// and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module rgcd_ctrl
    import rgcd_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(MW);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          out_free, last_bit, in_accept;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_bit  = (cnt_reg == CW'(MW - 1));
    assign in_accept = s_tvalid && (state_reg == S_IDLE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_MUL_P;
            S_MUL_P:    state_next = S_MUL_Q;
            S_MUL_Q:    state_next = S_MUL_D;
            S_MUL_D:    state_next = S_COMBINE;
            S_COMBINE:  state_next = stat.skip ? S_FINISH : S_GCD;
            S_GCD:      if (stat.gcd_done) state_next = S_DIV_NUM;
            S_DIV_NUM:  if (last_bit) state_next = S_LOAD_DEN;
            S_LOAD_DEN: state_next = S_DIV_DEN;
            S_DIV_DEN:  if (last_bit) state_next = S_FINISH;
            S_FINISH:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MSEL_P;
        cmd.load     = in_accept;
        unique case (state_reg)
            S_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_P;
            end
            S_MUL_Q: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_Q;
            end
            S_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_D;
            end
            S_COMBINE:  cmd.combine = 1'b1;
            S_GCD: begin
                cmd.gcd_step     = !stat.gcd_done;
                cmd.div_init_num = stat.gcd_done;
            end
            S_DIV_NUM:  cmd.div_step = 1'b1;
            S_LOAD_DEN: cmd.div_init_den = 1'b1;
            S_DIV_DEN:  cmd.div_step = 1'b1;
            S_FINISH:   cmd.out_load = out_free;
            default:    cmd.load = in_accept;
        endcase
    end

    // Bit counter for the divider and result valid.
    always_comb begin
        cnt_next = '0;
        if ((state_reg == S_DIV_NUM) || (state_reg == S_DIV_DEN)) begin
            cnt_next = last_bit ? '0 : (cnt_reg + CW'(1));
        end
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule
